FILE: sv/csvt_pkg.sv
package csvt_pkg;

  localparam logic [7:0] CHAR_CR = 8'd13;
  localparam logic [7:0] CHAR_LF = 8'd10;

  localparam logic [7:0] SEP_RESET = 8'd44;
  localparam logic [7:0] QUOTE_RESET = 8'd34;
  localparam logic [7:0] ESC_RESET = 8'd92;

  localparam logic [1:0] REG_SEP = 2'd0;
  localparam logic [1:0] REG_QUOTE = 2'd1;
  localparam logic [1:0] REG_ESC = 2'd2;

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    KIND_CONTENT = 2'd0,
    KIND_FIELD   = 2'd1,
    KIND_RECORD  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } tok_t;

  typedef struct packed {
    logic [1:0] cnt;
    tok_t       t0;
    tok_t       t1;
  } tok_pair_t;

endpackage

FILE: sv/csvt_core.sv
module csvt_core
  import csvt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       acc,
  input  logic [7:0] in_byte,
  input  logic       in_eos,
  output tok_pair_t  pair
);

  typedef struct packed {
    logic toggle;
    logic emit;
    tok_t tok;
  } tail_t;

  logic [7:0] sep_r, quote_r, esc_r;
  logic       iq_r, iq_nxt;
  logic [7:0] prev_r, prev_nxt;
  logic       pend_r, pend_nxt;
  logic [7:0] bbq_r, bbq_nxt;

  function automatic tail_t tail_eval(input logic [7:0] c, input logic [7:0] last,
                                      input logic [7:0] q, input logic [7:0] e);
    tail_t t;
    t = '0;
    t.tok.kind = KIND_CONTENT;
    if (c == q && last != e) begin
      t.toggle = 1'b1;
    end else if (c == e && last != e) begin
      t.emit = 1'b0;
    end else if (c == CHAR_CR) begin
      t.emit = 1'b0;
    end else if (c == CHAR_LF) begin
      t.emit = 1'b1;
      t.tok.kind = KIND_RECORD;
    end else begin
      t.emit = 1'b1;
      t.tok.data = c;
    end
    return t;
  endfunction

  tail_t tq, tb;
  logic  iq1;
  logic  h_emit;
  tok_t  h_tok;
  logic  q_emit;
  tok_t  q_tok;

  always_comb begin
    tq = tail_eval(quote_r, bbq_r, quote_r, esc_r);
    iq1 = iq_r ^ (pend_r & tq.toggle);
    tb = tail_eval(in_byte, prev_r, quote_r, esc_r);
    iq_nxt = iq1;
    prev_nxt = in_byte;
    pend_nxt = 1'b0;
    bbq_nxt = bbq_r;
    h_emit = 1'b0;
    h_tok = '0;
    h_tok.kind = KIND_CONTENT;
    q_emit = pend_r & tq.emit;
    q_tok = tq.tok;
    if (pend_r && in_byte == quote_r) begin
      q_emit = 1'b0;
      h_emit = 1'b1;
      h_tok.data = quote_r;
      iq_nxt = iq_r;
      prev_nxt = quote_r;
    end else if (in_byte == sep_r && !iq1 && prev_r != esc_r) begin
      h_emit = 1'b1;
      h_tok.kind = KIND_FIELD;
    end else if (in_byte == quote_r && !in_eos) begin
      pend_nxt = 1'b1;
      bbq_nxt = prev_r;
    end else begin
      iq_nxt = iq1 ^ tb.toggle;
      h_emit = tb.emit;
      h_tok = tb.tok;
    end
    if (in_eos) begin
      iq_nxt = 1'b0;
      prev_nxt = '0;
      pend_nxt = 1'b0;
      bbq_nxt = '0;
    end

    pair = '0;
    pair.t0.kind = KIND_CONTENT;
    pair.t1.kind = KIND_CONTENT;
    if (q_emit) begin
      pair.t0 = q_tok;
      if (h_emit) begin
        pair.t1 = h_tok;
        pair.t1.last = 1'b1;
        pair.cnt = 2'd2;
      end else begin
        pair.t0.last = 1'b1;
        pair.cnt = 2'd1;
      end
    end else if (h_emit) begin
      pair.t0 = h_tok;
      pair.t0.last = 1'b1;
      pair.cnt = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r <= SEP_RESET;
      quote_r <= QUOTE_RESET;
      esc_r <= ESC_RESET;
      iq_r <= 1'b0;
      prev_r <= '0;
      pend_r <= 1'b0;
      bbq_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SEP:   sep_r <= cfg_data;
          REG_QUOTE: quote_r <= cfg_data;
          REG_ESC:   esc_r <= cfg_data;
          default:   ;
        endcase
      end
      if (acc) begin
        iq_r <= iq_nxt;
        prev_r <= prev_nxt;
        pend_r <= pend_nxt;
        bbq_r <= bbq_nxt;
      end
    end
  end

endmodule

FILE: sv/csvt_outq.sv
module csvt_outq
  import csvt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  tok_pair_t pair,
  output logic      full2,
  output logic      out_valid,
  input  logic      out_stall,
  output tok_t      head
);

  tok_t           mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic [1:0]     npush;
  logic           pop;

  assign out_valid = (cnt_r != '0);
  assign full2 = (cnt_r > QCW'(QDEPTH - 2));
  assign pop = out_valid && !out_stall;
  assign npush = push ? pair.cnt : 2'd0;
  assign head = mem_r[rp_r];
  assign cnt_nxt = cnt_r + QCW'(npush) - QCW'(pop);

  always_ff @(posedge clk) begin
    if (npush != 2'd0) begin
      mem_r[wp_r] <= pair.t0;
    end
    if (npush == 2'd2) begin
      mem_r[wp_r + QAW'(1)] <= pair.t1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_r + QAW'(npush);
      if (pop) begin
        rp_r <= rp_r + QAW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: sv/csv_byte_tokenizer.sv
// Results are written into a result queue and shown on the outputs from its head.
// Throughput: one byte per cycle while in_stall is low; results leave one per cycle,
// when out_stall is low, through a four-entry result queue, one result at a time.
// Input stalls while the queue holds more than two results.
// Reset (synchronous, rst_n low): clears tokenizer state and queue, and loads
// the default separator, quote and escape bytes.
module csv_byte_tokenizer
  import csvt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_stream,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_token_kind,
  output logic [7:0] out_content_byte,
  output logic       out_last_of_run
);

  tok_pair_t pair;
  tok_t      head;
  logic      acc;
  logic      full2;

  assign in_stall = full2;
  assign acc = in_valid && !full2;

  csvt_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (acc),
    .in_byte   (in_byte),
    .in_eos    (in_end_of_stream),
    .pair      (pair)
  );

  csvt_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc),
    .pair      (pair),
    .full2     (full2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_token_kind = head.kind;
  assign out_content_byte = head.data;
  assign out_last_of_run = head.last;

endmodule
